@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gcomp_pkg.sv @@
// types, constants and gain arithmetic of the gain compensation curve
package gcomp_pkg;

    localparam int MAX_POINTS_DEF    = 8;
    localparam int CURVE_SAMPLES_DEF = 256;
    localparam int FIFO_DEPTH        = 4;
    localparam int LOC_W             = 5;
    localparam int LEV_W             = 4;
    localparam int GAIN_W            = 24;
    localparam int SAMPLES           = 8;

    localparam logic             ACT_END    = 1'b1;
    localparam logic [LEV_W-1:0] NORM_LEVEL = 4'd4;

    typedef enum logic {
        CMD_POINT = 1'b0,
        CMD_END   = 1'b1
    } kind_t;

    // on an end command lev carries the next frame's level code
    typedef struct packed {
        kind_t            kind;
        logic             ovf;
        logic [LOC_W-1:0] loc;
        logic [LEV_W-1:0] lev;
    } cmd_t;

    typedef struct packed {
        logic [LOC_W-1:0] loc;
        logic [LEV_W-1:0] lev;
    } point_t;

    typedef struct packed {
        logic [LOC_W-1:0]                segment;
        logic [SAMPLES-1:0][GAIN_W-1:0]  sample;
        logic [GAIN_W-1:0]               lead;
        logic                            error;
        logic                            last;
    } res_t;

    // 2^(r/8) in q1.23
    localparam logic [GAIN_W-1:0] FRAC [8] = '{
        24'd8388608, 24'd9147842, 24'd9975792, 24'd10878679,
        24'd11863283, 24'd12937002, 24'd14107901, 24'd15384775
    };

    // 2^(4-code) in q5.19
    localparam logic [GAIN_W-1:0] LEVEL_ROM [16] = '{
        24'd8388608, 24'd4194304, 24'd2097152, 24'd1048576,
        24'd524288, 24'd262144, 24'd131072, 24'd65536,
        24'd32768, 24'd16384, 24'd8192, 24'd4096,
        24'd2048, 24'd1024, 24'd512, 24'd256
    };

    // exponent in eighths of an octave for sample k of a ramp
    function automatic logic signed [8:0] ramp_exp(
        logic [LEV_W-1:0] f,
        logic [LEV_W-1:0] t,
        logic [2:0]       k
    );
        logic signed [8:0] base;
        logic signed [8:0] diff;
        logic signed [8:0] prod;
        base = 9'sd32 - $signed({2'b00, f, 3'b000});
        diff = $signed({5'b00000, f}) - $signed({5'b00000, t});
        prod = diff * $signed({6'b000000, k});
        return base + prod;
    endfunction

    function automatic logic [GAIN_W-1:0] gain_of(logic signed [8:0] e);
        logic signed [8:0]  q;
        logic signed [8:0]  s;
        logic [GAIN_W-1:0]  v;
        logic [4:0]         sh;
        logic [GAIN_W:0]    sum;
        logic [GAIN_W-1:0]  res;
        q = e >>> 3;
        s = 9'sd4 - q;
        v = FRAC[e[2:0]];
        if (s <= 9'sd0)
        begin
            res = v;
        end
        else
        begin
            if (s > 9'sd23)
            begin
                sh = 5'd23;
            end
            else
            begin
                sh = s[4:0];
            end
            sum = {1'b0, v} + ((GAIN_W+1)'(1) << (sh - 5'd1));
            res = GAIN_W'(sum >> sh);
        end
        return res;
    endfunction

endpackage

@@ rtl/gcomp_fifo.sv @@
// command queue between the front and back parts
module gcomp_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gcomp_pkg::cmd_t   push_data,
    output logic              full,
    input  logic              pop,
    output gcomp_pkg::cmd_t   pop_data,
    output logic              empty
);

    localparam int PTR_W = $clog2(gcomp_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(gcomp_pkg::FIFO_DEPTH + 1);

    gcomp_pkg::cmd_t   entry_reg [gcomp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(gcomp_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/gcomp_front.sv @@
// front part: accepts items, drops unusable points, flags overflow
module gcomp_front #(
    parameter int MAX_POINTS    = gcomp_pkg::MAX_POINTS_DEF,
    parameter int CURVE_SAMPLES = gcomp_pkg::CURVE_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic [gcomp_pkg::LOC_W-1:0]   location,
    input  logic [gcomp_pkg::LEV_W-1:0]   level,
    input  logic [gcomp_pkg::LEV_W-1:0]   next_level,
    output logic                          q_push,
    output gcomp_pkg::cmd_t               q_cmd,
    input  logic                          q_full
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [gcomp_pkg::LOC_W:0] NSEG = (gcomp_pkg::LOC_W+1)'(CURVE_SAMPLES / 8);

    logic [CNT_W-1:0]             count_reg;
    logic [gcomp_pkg::LOC_W-1:0]  last_loc_reg;
    logic                         ovf_reg;
    logic                         accept;
    logic                         is_end;
    logic                         in_range;
    logic                         advances;
    logic                         room;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_end   = (action == gcomp_pkg::ACT_END);
    assign in_range = ({1'b0, location} < NSEG);
    assign advances = (count_reg == '0) || (location > last_loc_reg);
    assign room     = (count_reg < CNT_W'(MAX_POINTS));
    assign q_push   = accept && (is_end || (in_range && advances && room));

    always_comb
    begin
        q_cmd.kind = is_end ? gcomp_pkg::CMD_END : gcomp_pkg::CMD_POINT;
        q_cmd.ovf  = ovf_reg;
        q_cmd.loc  = location;
        q_cmd.lev  = is_end ? next_level : level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            last_loc_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (is_end)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (in_range && advances)
            begin
                if (room)
                begin
                    count_reg    <= count_reg + CNT_W'(1);
                    last_loc_reg <= location;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/gcomp_back.sv @@
// back part: stores points and walks the segments of the curve
module gcomp_back #(
    parameter int MAX_POINTS    = gcomp_pkg::MAX_POINTS_DEF,
    parameter int CURVE_SAMPLES = gcomp_pkg::CURVE_SAMPLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  gcomp_pkg::cmd_t   q_cmd,
    output logic              q_pop,
    output gcomp_pkg::res_t   res,
    output logic              res_valid,
    input  logic              res_pop
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [gcomp_pkg::LOC_W-1:0] SEG_LAST =
        gcomp_pkg::LOC_W'(CURVE_SAMPLES / 8 - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD0,
        S_LD1,
        S_SEG,
        S_FETCH,
        S_ERR
    } state_t;

    gcomp_pkg::point_t  mem [MAX_POINTS];
    gcomp_pkg::point_t  rd_data_reg;

    state_t                                    state_reg;
    logic [CNT_W-1:0]                          n_reg;
    logic [CNT_W-1:0]                          idx_reg;
    logic [gcomp_pkg::LOC_W-1:0]               seg_reg;
    logic [gcomp_pkg::LEV_W-1:0]               g_reg;
    gcomp_pkg::point_t                         p_reg;
    gcomp_pkg::point_t                         q_reg;
    logic [gcomp_pkg::GAIN_W-1:0]              lead_reg;
    gcomp_pkg::res_t                           res_reg;
    logic                                      res_valid_reg;

    logic                                      out_free;
    logic                                      emit;
    logic                                      p_valid;
    logic                                      q_valid;
    logic                                      pass;
    logic [CNT_W:0]                            idx2;
    logic                                      fetch_need;
    logic [gcomp_pkg::LEV_W-1:0]               lev_from;
    logic [gcomp_pkg::LEV_W-1:0]               lev_to;
    logic [gcomp_pkg::SAMPLES-1:0][gcomp_pkg::GAIN_W-1:0] gains;
    logic                                      mem_we;
    logic                                      rd_en;
    logic [IDX_W-1:0]                          rd_addr;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign out_free  = !res_valid_reg || res_pop;
    assign emit      = out_free && ((state_reg == S_SEG) || (state_reg == S_ERR));
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign mem_we    = q_pop && (q_cmd.kind == gcomp_pkg::CMD_POINT);

    assign p_valid    = (idx_reg < n_reg);
    assign q_valid    = (({1'b0, idx_reg} + (CNT_W+1)'(1)) < {1'b0, n_reg});
    assign pass       = p_valid && (p_reg.loc == seg_reg);
    assign idx2       = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign fetch_need = pass && (idx2 < {1'b0, n_reg});
    assign lev_from   = pass ? p_reg.lev : g_reg;
    assign lev_to     = pass ? (q_valid ? q_reg.lev : gcomp_pkg::NORM_LEVEL) : g_reg;

    always_comb
    begin
        for (int k = 0; k < gcomp_pkg::SAMPLES; k++)
        begin
            gains[k] = gcomp_pkg::gain_of(gcomp_pkg::ramp_exp(lev_from, lev_to, 3'(k)));
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en   = q_pop && (q_cmd.kind == gcomp_pkg::CMD_END) && (n_reg != '0);
                rd_addr = '0;
            end
            S_LD0:
            begin
                rd_en   = (n_reg > CNT_W'(1));
                rd_addr = IDX_W'(1);
            end
            S_SEG:
            begin
                rd_en   = out_free && fetch_need;
                rd_addr = idx2[IDX_W-1:0];
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    // point store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[n_reg[IDX_W-1:0]] <= '{loc: q_cmd.loc, lev: q_cmd.lev};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            idx_reg       <= '0;
            seg_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_pop && res_valid_reg && !emit)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_cmd.kind == gcomp_pkg::CMD_POINT)
                        begin
                            n_reg <= n_reg + CNT_W'(1);
                        end
                        else
                        begin
                            lead_reg <= gcomp_pkg::LEVEL_ROM[q_cmd.lev];
                            seg_reg  <= '0;
                            idx_reg  <= '0;
                            if (q_cmd.ovf)
                            begin
                                state_reg <= S_ERR;
                            end
                            else if (n_reg == '0)
                            begin
                                g_reg     <= gcomp_pkg::NORM_LEVEL;
                                state_reg <= S_SEG;
                            end
                            else
                            begin
                                state_reg <= S_LD0;
                            end
                        end
                    end
                end
                S_LD0:
                begin
                    p_reg     <= rd_data_reg;
                    g_reg     <= rd_data_reg.lev;
                    state_reg <= (n_reg > CNT_W'(1)) ? S_LD1 : S_SEG;
                end
                S_LD1:
                begin
                    q_reg     <= rd_data_reg;
                    state_reg <= S_SEG;
                end
                S_SEG:
                begin
                    if (out_free)
                    begin
                        res_valid_reg   <= 1'b1;
                        res_reg.segment <= seg_reg;
                        res_reg.sample  <= gains;
                        res_reg.lead    <= lead_reg;
                        res_reg.error   <= 1'b0;
                        res_reg.last    <= (seg_reg == SEG_LAST);
                        if (pass)
                        begin
                            g_reg   <= lev_to;
                            p_reg   <= q_reg;
                            idx_reg <= idx_reg + CNT_W'(1);
                        end
                        if (seg_reg == SEG_LAST)
                        begin
                            n_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            seg_reg   <= seg_reg + gcomp_pkg::LOC_W'(1);
                            state_reg <= fetch_need ? S_FETCH : S_SEG;
                        end
                    end
                end
                S_FETCH:
                begin
                    q_reg     <= rd_data_reg;
                    state_reg <= S_SEG;
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        res_valid_reg   <= 1'b1;
                        res_reg.segment <= '0;
                        res_reg.sample  <= '0;
                        res_reg.lead    <= lead_reg;
                        res_reg.error   <= 1'b1;
                        res_reg.last    <= 1'b1;
                        n_reg           <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/gain_compensation_curve_core.sv @@
// top level of the gain compensation curve block
//
//  channel   handshake            beat
//  input     push / full          action, location, level, next_level
//  result    empty / pop          segment, sample_0..7, lead_in_scale, error, last
//
// a point beat passes the front and the command queue into the back store
// an end beat yields CURVE_SAMPLES/8 result beats after its pop and the point
// loads (S_LD0, S_LD1), one per cycle from the segment walker while pops keep
// up; each point beyond the second is read in an S_FETCH step between beats
// an end beat after too many points yields a single error beat
// a four-entry command queue lets the front take beats while the back walks
// reset clears control state only, the point store needs no clearing pass
`include "assert_macros.svh"

module gain_compensation_curve_core #(
    parameter int MAX_POINTS    = gcomp_pkg::MAX_POINTS_DEF,
    parameter int CURVE_SAMPLES = gcomp_pkg::CURVE_SAMPLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           action,
    input  logic [gcomp_pkg::LOC_W-1:0]    location,
    input  logic [gcomp_pkg::LEV_W-1:0]    level,
    input  logic [gcomp_pkg::LEV_W-1:0]    next_level,
    output logic                           empty,
    input  logic                           pop,
    output logic [gcomp_pkg::LOC_W-1:0]    segment,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_0,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_1,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_2,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_3,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_4,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_5,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_6,
    output logic [gcomp_pkg::GAIN_W-1:0]   sample_7,
    output logic [gcomp_pkg::GAIN_W-1:0]   lead_in_scale,
    output logic                           error,
    output logic                           last
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    gcomp_pkg::cmd_t   q_in;
    gcomp_pkg::cmd_t   q_out;
    gcomp_pkg::res_t   res;
    logic              res_valid;

    gcomp_front #(
        .MAX_POINTS    (MAX_POINTS),
        .CURVE_SAMPLES (CURVE_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .location   (location),
        .level      (level),
        .next_level (next_level),
        .q_push     (q_push),
        .q_cmd      (q_in),
        .q_full     (q_full)
    );

    gcomp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    gcomp_back #(
        .MAX_POINTS    (MAX_POINTS),
        .CURVE_SAMPLES (CURVE_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_out),
        .q_pop     (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty         = !res_valid;
    assign segment       = res.segment;
    assign sample_0      = res.sample[0];
    assign sample_1      = res.sample[1];
    assign sample_2      = res.sample[2];
    assign sample_3      = res.sample[3];
    assign sample_4      = res.sample[4];
    assign sample_5      = res.sample[5];
    assign sample_6      = res.sample[6];
    assign sample_7      = res.sample[7];
    assign lead_in_scale = res.lead;
    assign error         = res.error;
    assign last          = res.last;

    `ASSERT_IMPL(a_no_push_when_full, q_push, !q_full, "command pushed into full queue")
    `ASSERT_IMPL(a_error_is_last, !empty && error, last, "error beat not marked last")
    `ASSERT_IMPL(a_error_seg_zero, !empty && error, segment == '0 && sample_0 == '0, "error beat carries data")
    `ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(segment) && $stable(lead_in_scale), "waiting beat changed")

endmodule
